// ----- rtl/core/pekx_pkg.sv -----
// shared types and constants for the pressure knot extractor
package pekx_pkg;

  localparam int unsigned LEN_W = 40;
  localparam int unsigned P_W   = 16;
  localparam int unsigned Q_W   = 17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_STORE,
    S_FIRST_RD,
    S_DIV,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_SHORT
  } state_t;

  typedef enum logic [1:0] {
    DK_FIRST,
    DK_INNER,
    DK_LAST
  } knot_kind_t;

  typedef struct packed {
    logic       load;
    logic       sqrt_start;
    logic       store;
    logic       clear;
    logic       rd_first;
    logic       rd_scan;
    logic       eval;
    logic       div_start;
    knot_kind_t kind;
    logic       emit;
    logic       emit_short;
  } ctl_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic first_sample;
    logic is_final;
    logic full;
    logic short_stroke;
    logic scan_more;
    logic knot_hit;
  } sts_t;

endpackage

// ----- rtl/core/pekx_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module pekx_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [65:0] radicand,
  output logic [32:0] root,
  output logic        done
);
  logic [65:0] rem;
  logic [32:0] res;
  logic [65:0] src;
  logic [5:0]  cnt;
  logic        run;
  logic [67:0] trial;
  logic [67:0] rem_sh;

  assign rem_sh = {rem, src[65:64]};
  assign trial  = {33'd0, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      res <= '0;
      src <= radicand;
    end else if (run) begin
      src <= {src[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= 66'(rem_sh - trial);
        res <= {res[31:0], 1'b1};
      end else begin
        rem <= rem_sh[65:0];
        res <= {res[31:0], 1'b0};
      end
    end
  end

  assign root = res;
endmodule

// ----- rtl/core/pekx_div.sv -----
// restoring divider for q16 fractions, one quotient bit per cycle
module pekx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [39:0] divisor,
  output logic [16:0] quotient,
  output logic        done
);
  logic [55:0] num;
  logic [40:0] rem;
  logic [16:0] q;
  logic [39:0] den;
  logic [5:0]  cnt;
  logic        run;
  logic [40:0] rem_sh;

  // quotient fits in 17 bits, so the top 39 dividend bits start as remainder
  assign rem_sh = {rem[39:0], num[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd16) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, dividend[55:17]};
      num <= dividend;
      den <= divisor;
      q   <= '0;
    end else if (run) begin
      num <= {num[54:0], 1'b0};
      if (rem_sh >= {1'b0, den}) begin
        rem <= 41'(rem_sh - {1'b0, den});
        q   <= {q[15:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[15:0], 1'b0};
      end
    end
  end

  assign quotient = q;
endmodule

// ----- rtl/core/pekx_datapath.sv -----
// stroke datapath: sample stores, length accumulation, knot scan and scaling
module pekx_datapath #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pekx_pkg::ctl_t       ctl,
  output pekx_pkg::sts_t       sts,
  input  logic [31:0]          coord_x,
  input  logic [31:0]          coord_y,
  input  logic [15:0]          pressure,
  input  logic                 final_sample,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output logic [16:0]          knot_position,
  output logic [16:0]          knot_pressure,
  output logic                 last_knot,
  output logic [1:0]           status,
  output logic                 strobe
);
  import pekx_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic [15:0]    pmem [MAX_SAMPLES];
  logic [LEN_W-1:0] lmem [MAX_SAMPLES];

  logic [15:0] full_scale;
  logic [31:0] in_x, in_y, prev_x, prev_y;
  logic [15:0] in_p;
  logic        in_fin;
  logic [LEN_W-1:0] run_len;
  logic [15:0] peak;
  logic [CW-1:0] count;
  logic        ovf;

  logic [32:0] dx, dy;
  logic [65:0] sq_sum;
  logic [32:0] root;
  logic [65:0] dxx, dyy;
  logic [1:0]  msq;

  logic [CW-1:0] idx;
  logic [15:0]   rd_p, rd_pp;
  logic [LEN_W-1:0] rd_l, total, lastpos;
  logic signed [16:0] lastdiff, diff;
  logic [15:0]   knot_p;
  logic [LEN_W-1:0] knot_l;
  logic [16:0]   qpos, qprs;
  logic [1:0]    dphase;
  logic          div_start, div_go;
  logic [55:0]   div_num;
  logic [39:0]   div_den;
  logic [16:0]   div_q;
  logic          div_done;
  logic [15:0]   divisor;

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) full_scale <= 16'hFFFF;
    else if (cfg_we) full_scale <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_x <= coord_x; in_y <= coord_y; in_p <= pressure; in_fin <= final_sample;
      dx <= absd(prev_x, coord_x);
      dy <= absd(prev_y, coord_y);
      msq <= 2'd0;
    end else if (msq != 2'd2) begin
      msq <= msq + 2'd1;
      if (msq == 2'd0) begin
        dxx <= dx * dx;
        dyy <= dy * dy;
      end else begin
        sq_sum <= dxx + dyy;
      end
    end
  end

  pekx_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(ctl.sqrt_start), .radicand(sq_sum),
    .root(root), .done(sts.sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prev_x <= '0; prev_y <= '0; run_len <= '0; peak <= '0; count <= '0; ovf <= 1'b0;
    end else if (ctl.store) begin
      if (count < CW'(MAX_SAMPLES)) begin
        if (count != '0) begin
          run_len <= LEN_W'(run_len + LEN_W'(root));
        end
        prev_x <= in_x; prev_y <= in_y;
        if (in_p > peak) peak <= in_p;
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store && count < CW'(MAX_SAMPLES)) begin
      pmem[count[AW-1:0]] <= in_p;
      lmem[count[AW-1:0]] <= (count != '0) ? LEN_W'(run_len + LEN_W'(root)) : run_len;
    end
  end

  assign sts.first_sample = 1'b0;
  assign sts.is_final     = in_fin;
  assign sts.full         = count >= CW'(MAX_SAMPLES);
  assign sts.short_stroke = count < CW'(2);
  assign divisor = (peak > full_scale) ? peak : ((full_scale == 16'd0) ? 16'd1 : full_scale);
  assign diff = $signed({1'b0, rd_p}) - $signed({1'b0, rd_pp});

  // scan first reads samples 0 and 1, then length n-2 and pressure n-1, then inner samples 1..n-2
  always_ff @(posedge clk) begin
    if (ctl.rd_first) begin
      case (dphase)
        2'd0: begin
          rd_p <= pmem[0]; rd_pp <= pmem[1]; dphase <= 2'd1;
        end
        2'd1: begin
          total <= lmem[AW'(count - CW'(2))];
          dphase <= 2'd2;
        end
        default: begin
          lastdiff <= $signed({1'b0, rd_pp}) - $signed({1'b0, rd_p});
          knot_p <= rd_p; lastpos <= '0; idx <= CW'(1);
          dphase <= 2'd3;
        end
      endcase
    end else if (ctl.rd_scan) begin
      rd_p  <= pmem[idx[AW-1:0]];
      rd_pp <= pmem[AW'(idx - CW'(1))];
      rd_l  <= lmem[AW'(idx - CW'(1))];
      dphase <= 2'd0;
    end else if (ctl.eval) begin
      idx <= idx + CW'(1);
      if (rd_l > lastpos) begin
        lastpos <= rd_l;
        if (sts.knot_hit) begin
          lastdiff <= diff;
          knot_p <= rd_p; knot_l <= rd_l;
        end
      end
    end else begin
      dphase <= 2'd0;
    end
  end

  assign sts.knot_hit = (rd_l > lastpos) &&
      ((diff > 0 && lastdiff <= 0) || (diff < 0 && lastdiff >= 0));
  assign sts.scan_more = (idx + CW'(1)) < count;

  // pressure division per knot, then a position division for an inner knot with nonzero length
  logic [15:0] last_p;
  always_ff @(posedge clk) begin
    if (ctl.rd_first && dphase == 2'd1) last_p <= pmem[AW'(count - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0; div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (ctl.div_start) begin
        div_go <= 1'b1; div_start <= 1'b1;
        div_num <= {24'd0, (ctl.kind == DK_LAST) ? last_p : knot_p, 16'd0};
        div_den <= {24'd0, divisor};
      end else if (div_done && div_go) begin
        div_go <= 1'b0;
        qprs <= div_q;
        if (ctl.kind == DK_INNER && total != '0) begin
          div_start <= 1'b1;
          div_num <= {knot_l, 16'd0};
          div_den <= total;
        end
      end else if (div_done) begin
        qpos <= div_q;
      end
    end
  end

  pekx_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .quotient(div_q), .done(div_done)
  );

  // quotients are registered, so the knot is ready in the cycle after the last done
  logic div_fin;
  always_ff @(posedge clk) begin
    if (rst) div_fin <= 1'b0;
    else div_fin <= (div_done && div_go && !(ctl.kind == DK_INNER && total != '0))
                    || (div_done && !div_go);
  end
  assign sts.div_done = div_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit || ctl.emit_short;
      if (ctl.emit_short) begin
        knot_position <= '0; knot_pressure <= '0; last_knot <= 1'b1; status <= ST_SHORT;
      end else if (ctl.emit) begin
        knot_pressure <= qprs;
        last_knot <= (ctl.kind == DK_LAST);
        status <= ovf ? ST_DROP : ST_OK;
        case (ctl.kind)
          DK_FIRST: knot_position <= '0;
          DK_LAST:  knot_position <= (total != '0) ? 17'h10000 : 17'd0;
          default:  knot_position <= (total != '0) ? qpos : 17'd0;
        endcase
      end
    end
  end
endmodule

// ----- rtl/core/pekx_ctrl.sv -----
// stroke controller state machine
module pekx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pekx_pkg::sts_t sts,
  output pekx_pkg::ctl_t ctl
);
  import pekx_pkg::*;

  state_t state, state_next;
  knot_kind_t kind, kind_next;
  logic [1:0] wait_cnt, wait_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; kind <= DK_FIRST; wait_cnt <= '0;
    end else begin
      state <= state_next; kind <= kind_next; wait_cnt <= wait_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next = kind;
    wait_cnt_next = wait_cnt;
    ctl = '0;
    ctl.kind = kind;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1; wait_cnt_next = '0; state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        // a multiply stage and a sum stage, then the root
        if (wait_cnt != 2'd3) begin
          wait_cnt_next = wait_cnt + 2'd1;
          if (wait_cnt == 2'd2) ctl.sqrt_start = 1'b1;
        end else if (sts.sqrt_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        ctl.store = 1'b1;
        if (sts.is_final) state_next = S_FIRST_RD;
        else state_next = S_IDLE;
        wait_cnt_next = '0;
      end
      S_FIRST_RD: begin
        if (sts.short_stroke) begin
          state_next = S_SHORT;
        end else begin
          ctl.rd_first = 1'b1;
          wait_cnt_next = wait_cnt + 2'd1;
          if (wait_cnt == 2'd2) begin
            kind_next = DK_FIRST; state_next = S_DIV; ctl.div_start = 1'b0;
          end
        end
      end
      S_SHORT: begin
        ctl.emit_short = 1'b1; ctl.clear = 1'b1; state_next = S_IDLE;
      end
      S_DIV: begin
        ctl.div_start = 1'b1; state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.div_done) begin
          ctl.emit = 1'b1;
          case (kind)
            DK_LAST: begin
              ctl.clear = 1'b1; state_next = S_IDLE;
            end
            default: begin
              state_next = S_SCAN_RD;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_more) begin
          ctl.rd_scan = 1'b1; state_next = S_SCAN_EVAL;
        end else begin
          kind_next = DK_LAST; state_next = S_DIV;
        end
      end
      S_SCAN_EVAL: begin
        ctl.eval = 1'b1;
        if (sts.knot_hit) begin
          kind_next = DK_INNER; state_next = S_DIV;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ctl.emit) else $error("emit while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !busy) else $error("load while busy");
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (state == S_IDLE)) else $error("clear not at stroke end");
endmodule

// ----- rtl/core/pressure_extrema_knot_extractor_core.sv -----
// top level of the pressure knot extractor
// a sample keeps busy high after its accept through a multiply stage, a sum stage, the 33-step root and the store
// after the final sample each knot takes one divider run, an inner knot with nonzero length two,
// plus a read and an evaluate state per scanned inner sample
// synchronous active-high reset clears stroke state; full scale resets to 65535
// results are one-cycle strobes and the receiver cannot stall
module pressure_extrema_knot_extractor_core #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [15:0] pressure,
  input  logic        final_sample,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [16:0] knot_position,
  output logic [16:0] knot_pressure,
  output logic        last_knot,
  output logic [1:0]  status
);
  import pekx_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pekx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  pekx_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .coord_x(coord_x), .coord_y(coord_y), .pressure(pressure),
    .final_sample(final_sample), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .knot_position(knot_position), .knot_pressure(knot_pressure),
    .last_knot(last_knot), .status(status), .strobe(strobe)
  );
endmodule

// ----- tb/pressure_extrema_knot_extractor_core_test.sv -----
// self-checking testbench for the pressure knot extractor core
module pressure_extrema_knot_extractor_core_test;
  import pekx_pkg::*;

  localparam int unsigned CAPACITY = 64;

  typedef struct {
    logic [Q_W-1:0] position;
    logic [Q_W-1:0] level;
    logic           last;
    logic [1:0]     st;
  } knot_t;

  typedef struct {
    logic [31:0]    x;
    logic [31:0]    y;
    logic [P_W-1:0] p;
    logic           fin;
    logic           typed;
    knot_t          knot;
  } sample_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [31:0]       coord_x = '0;
  logic [31:0]       coord_y = '0;
  logic [P_W-1:0]    pressure = '0;
  logic              final_sample = 1'b0;
  logic              cfg_we = 1'b0;
  logic [15:0]       cfg_data = '0;
  logic              strobe;
  logic [Q_W-1:0]    knot_position;
  logic [Q_W-1:0]    knot_pressure;
  logic              last_knot;
  logic [1:0]        status;

  // predictor state
  logic [15:0]       full_scale;
  logic [P_W-1:0]    pres_mem [CAPACITY];
  logic [LEN_W-1:0]  len_mem [CAPACITY];
  logic [31:0]       last_x, last_y;
  logic [LEN_W-1:0]  path_len;
  logic [P_W-1:0]    peak;
  int unsigned       stored;
  logic              dropped;

  knot_t             knots_due[$];
  knot_t             fresh[$];
  sample_row_t       dir_rows[$];
  int unsigned       mismatches = 0;
  int unsigned       knots_seen = 0;
  int unsigned       strokes = 0;
  int unsigned       samples_sent = 0;
  int unsigned       overflow_strokes = 0;
  logic [31:0]       gx, gy;
  logic [P_W-1:0]    gp;

  pressure_extrema_knot_extractor_core #(.MAX_SAMPLES(CAPACITY)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .pressure(pressure),
    .final_sample(final_sample), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .strobe(strobe), .knot_position(knot_position), .knot_pressure(knot_pressure),
    .last_knot(last_knot), .status(status)
  );

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [34:0] int_sqrt(logic [69:0] v);
    logic [69:0] r;
    logic [69:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (70'd1 << b);
      if (c * c <= v) r = c;
    end
    return r[34:0];
  endfunction

  function automatic longint unsigned span(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [Q_W-1:0] frac(longint unsigned num, longint unsigned den);
    return Q_W'((num << 16) / den);
  endfunction

  task automatic clear_stroke_state();
    last_x = '0;
    last_y = '0;
    path_len = '0;
    peak = '0;
    stored = 0;
    dropped = 1'b0;
  endtask

  task automatic push_fresh(logic [Q_W-1:0] pos, logic [Q_W-1:0] lvl, logic lst,
                            logic [1:0] st);
    knot_t k;
    k.position = pos;
    k.level = lvl;
    k.last = lst;
    k.st = st;
    fresh.push_back(k);
  endtask

  // updates stroke state and leaves the knots caused in fresh
  task automatic knot_predict(logic [31:0] x, logic [31:0] y, logic [P_W-1:0] p,
                              logic fin);
    logic [69:0]      sq;
    longint unsigned  dx, dy, total, pos, lastpos, divisor;
    logic [1:0]       st;
    int               diff, lastdiff;
    fresh.delete();
    if (stored < CAPACITY) begin
      if (stored > 0) begin
        dx = span(last_x, x);
        dy = span(last_y, y);
        sq = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy);
        path_len = path_len + LEN_W'(int_sqrt(sq));
      end
      pres_mem[stored] = p;
      len_mem[stored] = path_len;
      last_x = x;
      last_y = y;
      if (p > peak) peak = p;
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!fin) return;
    strokes++;
    if (dropped) overflow_strokes++;
    if (stored < 2) begin
      push_fresh('0, '0, 1'b1, ST_SHORT);
      clear_stroke_state();
      return;
    end
    st = dropped ? ST_DROP : ST_OK;
    divisor = peak > full_scale ? peak : full_scale;
    if (divisor == 0) divisor = 1;
    total = len_mem[stored-2];
    push_fresh('0, frac(pres_mem[0], divisor), 1'b0, st);
    lastpos = 0;
    lastdiff = int'(pres_mem[1]) - int'(pres_mem[0]);
    for (int i = 1; i + 1 < stored; i++) begin
      pos = len_mem[i-1];
      if (pos > lastpos) begin
        diff = int'(pres_mem[i]) - int'(pres_mem[i-1]);
        lastpos = pos;
        if ((diff > 0 && lastdiff <= 0) || (diff < 0 && lastdiff >= 0)) begin
          push_fresh(total != 0 ? frac(pos, total) : '0, frac(pres_mem[i], divisor),
                     1'b0, st);
          lastdiff = diff;
        end
      end
    end
    push_fresh(total != 0 ? Q_W'(65536) : '0, frac(pres_mem[stored-1], divisor),
               1'b1, st);
    clear_stroke_state();
  endtask

  // one transaction; start stays high across back-to-back samples
  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [P_W-1:0] p,
                             logic fin, logic typed, knot_t typed_knot);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    coord_x = x;
    coord_y = y;
    pressure = p;
    final_sample = fin;
    start = 1'b1;
    do @(posedge clk); while (busy);
    knot_predict(x, y, p, fin);
    samples_sent++;
    if (typed && fresh.size() > 0) knots_due.push_back(typed_knot);
    else foreach (fresh[i]) knots_due.push_back(fresh[i]);
  endtask

  task automatic write_full_scale(logic [15:0] v);
    @(negedge clk);
    start = 1'b0;
    wait (knots_due.size() == 0);
    repeat (120) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    full_scale = v;
  endtask

  task automatic next_point();
    case ($urandom_range(0, 7))
      0: begin gx = $urandom; gy = $urandom; end
      1: begin gx = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
               gy = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff; end
      2: ;
      default: begin
        gx = gx + 32'($signed($urandom_range(0, 2000)) - 1000);
        gy = gy + 32'($signed($urandom_range(0, 2000)) - 1000);
      end
    endcase
    case ($urandom_range(0, 5))
      0: gp = 16'($urandom);
      1: gp = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      2: ;
      default: gp = gp + 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endtask

  task automatic random_stroke(int unsigned n);
    knot_t none;
    none = '{default: '0};
    if ($urandom_range(0, 1)) begin gx = $urandom; gy = $urandom; end
    else begin gx = 32'($urandom_range(0, 4000)); gy = 32'($urandom_range(0, 4000)); end
    gp = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      next_point();
      send_sample(gx, gy, gp, i == n - 1, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    knot_t e;
    if (!rst && strobe) begin
      knots_seen++;
      if (knots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected knot pos=%0d prs=%0d", knot_position,
                                       knot_pressure);
      end else begin
        e = knots_due.pop_front();
        if (knot_position !== e.position || knot_pressure !== e.level ||
            last_knot !== e.last || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("knot mismatch exp pos=%0d prs=%0d last=%0b st=%0d got %0d %0d %0b %0d",
                     e.position, e.level, e.last, e.st, knot_position, knot_pressure,
                     last_knot, status);
        end
      end
    end
  end

  initial begin
    knot_t short_knot;
    knot_t none;
    logic [15:0] scales[4];
    none = '{default: '0};
    short_knot = '{position: '0, level: '0, last: 1'b1, st: ST_SHORT};
    full_scale = 16'hffff;
    clear_stroke_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lone sample, extreme coordinates, zero length, two samples, slope turns
    dir_rows.push_back('{5, 5, 100, 1, 1, short_knot});
    dir_rows.push_back('{32'h8000_0000, 32'h8000_0000, 0, 0, 0, none});
    dir_rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 0, 0, none});
    dir_rows.push_back('{32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, none});
    dir_rows.push_back('{0, 0, 16'hffff, 0, 0, none});
    dir_rows.push_back('{100, -100, 16'hffff, 1, 0, none});
    dir_rows.push_back('{7, 7, 10, 0, 0, none});
    dir_rows.push_back('{7, 7, 500, 0, 0, none});
    dir_rows.push_back('{7, 7, 10, 0, 0, none});
    dir_rows.push_back('{7, 7, 10, 1, 0, none});
    dir_rows.push_back('{0, 0, 16'hffff, 0, 0, none});
    dir_rows.push_back('{3, 4, 0, 1, 0, none});
    dir_rows.push_back('{0, 0, 10, 0, 0, none});
    dir_rows.push_back('{10, 0, 20, 0, 0, none});
    dir_rows.push_back('{20, 0, 30, 0, 0, none});
    dir_rows.push_back('{30, 0, 20, 0, 0, none});
    dir_rows.push_back('{40, 0, 10, 0, 0, none});
    dir_rows.push_back('{50, 0, 10, 0, 0, none});
    dir_rows.push_back('{60, 0, 40, 0, 0, none});
    dir_rows.push_back('{70, 0, 5, 1, 0, none});
    foreach (dir_rows[i])
      send_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].p, dir_rows[i].fin,
                  dir_rows[i].typed, dir_rows[i].knot);

    scales[0] = 16'd1;
    scales[1] = 16'($urandom_range(1, 65535));
    scales[2] = 16'd300;
    scales[3] = 16'hffff;
    for (int ph = 0; ph < 4; ph++) begin
      write_full_scale(scales[ph]);
      if (ph == 1) random_stroke(CAPACITY);
      if (ph == 2) random_stroke(CAPACITY + 2 + $urandom_range(0, 3));
      if (ph == 3) random_stroke(1);
      for (int s = 0; s < 5; s++)
        random_stroke($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 12));
    end

    @(negedge clk);
    start = 1'b0;
    wait (knots_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d samples in %0d strokes (%0d over capacity), checked %0d knots",
             samples_sent, strokes, overflow_strokes, knots_seen);
    $display("covered four full-scale settings, short and zero-length strokes");
    if (mismatches == 0 && knots_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
